// ===== hw/rtl/sua_pkg.sv =====
// shared types, codes and constants of the set/ua link handshake block
`timescale 1ns / 1ps

package sua_pkg;

    // frame delimiter
    localparam logic [7:0] FLAG_BYTE = 8'h7e;

    // number of bytes in a set frame and index of its closing flag
    localparam int unsigned FRAME_BYTES = 5;
    localparam logic [2:0]  BEAT_LAST   = 3'(FRAME_BYTES - 1);

    // request kinds on the input channel
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // reported link status
    localparam logic [1:0] STAT_WAIT = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_FAIL = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_MAXTRIES = 3'd1;
    localparam logic [2:0] REG_ADDRESS  = 3'd2;
    localparam logic [2:0] REG_SETCTRL  = 3'd3;
    localparam logic [2:0] REG_UACTRL   = 3'd4;

    // register reset values
    localparam logic [15:0] RST_TIMEOUT  = 16'd2;
    localparam logic [3:0]  RST_MAXTRIES = 4'd3;
    localparam logic [7:0]  RST_ADDRESS  = 8'd3;
    localparam logic [7:0]  RST_SETCTRL  = 8'd3;
    localparam logic [7:0]  RST_UACTRL   = 8'd7;

    // handshake mode
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_WAIT = 4'b0010,
        MODE_DONE = 4'b0100,
        MODE_FAIL = 4'b1000
    } link_mode_t;

    // ua frame recognizer state
    typedef enum logic [4:0] {
        FS_START = 5'b00001,
        FS_FLAG  = 5'b00010,
        FS_ADDR  = 5'b00100,
        FS_CTRL  = 5'b01000,
        FS_CHECK = 5'b10000
    } frame_state_t;

    // recognizer step result
    typedef struct packed {
        frame_state_t next_state;
        logic         complete;
    } match_res_t;

endpackage

// ===== hw/rtl/sua_rx_match.sv =====
// ua frame recognizer: one received byte advances the frame state
`timescale 1ns / 1ps

module sua_rx_match (
    input  sua_pkg::frame_state_t frame_state,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            address_byte,
    input  logic [7:0]            ua_control,
    output sua_pkg::match_res_t   res
);

    logic [7:0] check_byte;
    logic       is_flag;

    assign check_byte = address_byte ^ ua_control;
    assign is_flag    = (rx_byte == sua_pkg::FLAG_BYTE);

    // match test first, then flag resync, else restart
    always_comb begin
        res.complete   = 1'b0;
        res.next_state = sua_pkg::FS_START;
        case (frame_state)
            sua_pkg::FS_START: begin
                if (is_flag) res.next_state = sua_pkg::FS_FLAG;
            end
            sua_pkg::FS_FLAG: begin
                if (rx_byte == address_byte) res.next_state = sua_pkg::FS_ADDR;
                else if (is_flag)            res.next_state = sua_pkg::FS_FLAG;
            end
            sua_pkg::FS_ADDR: begin
                if (rx_byte == ua_control) res.next_state = sua_pkg::FS_CTRL;
                else if (is_flag)          res.next_state = sua_pkg::FS_FLAG;
            end
            sua_pkg::FS_CTRL: begin
                if (rx_byte == check_byte) res.next_state = sua_pkg::FS_CHECK;
                else if (is_flag)          res.next_state = sua_pkg::FS_FLAG;
            end
            sua_pkg::FS_CHECK: begin
                res.complete = is_flag;
            end
            default: begin
                res.next_state = sua_pkg::FS_START;
            end
        endcase
    end

endmodule

// ===== hw/rtl/set_ua_link_handshake_unit.sv =====
// top level of the set/ua link handshake block, transmitter side
//
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tuser action, s_tdata rx_byte
// m_        out  m_tvalid / m_tready    m_tdata tx_byte,tx_valid,link_status; m_tlast
// apb       in   psel,penable,pwrite    paddr, pwdata, prdata (pready tied high)
//
// a request is handled in the cycle it is accepted; its results sit in the output register
// a start or a retrying timeout gives five beats, one per cycle; anything else gives one beat
// a new request is taken in the cycle the last beat of the previous one leaves, so single-beat
// requests run at one per cycle with m_tready high; a frame holds the input to its last beat
// m_tready low holds the output register and stalls the input side
// reset (aresetn low, synchronous) sets idle mode and the register defaults
`timescale 1ns / 1ps

module set_ua_link_handshake_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [8] tx_valid, [10:9] link_status, zero fill
    output logic        m_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [15:0] timeout_ticks_reg;
    logic [3:0]  try_limit_reg;
    logic [7:0]  address_byte_reg;
    logic [7:0]  set_control_reg;
    logic [7:0]  ua_control_reg;

    // handshake state
    sua_pkg::link_mode_t   mode_reg, mode_next;
    sua_pkg::frame_state_t frame_reg, frame_next;
    logic [15:0]           timer_reg, timer_next;
    logic [3:0]            tries_reg, tries_next;

    // output register
    logic       out_valid_reg;
    logic       is_frame_reg, is_frame_next;
    logic [2:0] beat_reg;
    logic [7:0] addr_reg;
    logic [7:0] ctrl_reg;
    logic [1:0] status_reg, status_next;

    logic                 in_fire;
    logic                 out_fire;
    logic                 last_beat;
    logic                 cfg_write;
    logic [2:0]           cfg_index;
    logic [15:0]          timer_inc;
    logic [7:0]           tx_byte;
    sua_pkg::match_res_t  match;

    // configuration write and read
    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= sua_pkg::RST_TIMEOUT;
            try_limit_reg     <= sua_pkg::RST_MAXTRIES;
            address_byte_reg  <= sua_pkg::RST_ADDRESS;
            set_control_reg   <= sua_pkg::RST_SETCTRL;
            ua_control_reg    <= sua_pkg::RST_UACTRL;
        end else if (cfg_write) begin
            case (cfg_index)
                sua_pkg::REG_TIMEOUT:  timeout_ticks_reg <= pwdata[15:0];
                sua_pkg::REG_MAXTRIES: try_limit_reg     <= pwdata[3:0];
                sua_pkg::REG_ADDRESS:  address_byte_reg  <= pwdata[7:0];
                sua_pkg::REG_SETCTRL:  set_control_reg   <= pwdata[7:0];
                sua_pkg::REG_UACTRL:   ua_control_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            sua_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout_ticks_reg};
            sua_pkg::REG_MAXTRIES: prdata = {28'd0, try_limit_reg};
            sua_pkg::REG_ADDRESS:  prdata = {24'd0, address_byte_reg};
            sua_pkg::REG_SETCTRL:  prdata = {24'd0, set_control_reg};
            sua_pkg::REG_UACTRL:   prdata = {24'd0, ua_control_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // handshakes
    assign last_beat = !is_frame_reg || (beat_reg == sua_pkg::BEAT_LAST);
    assign out_fire  = out_valid_reg && m_tready;
    assign s_tready  = aresetn && (!out_valid_reg || (m_tready && last_beat));
    assign in_fire   = s_tvalid && s_tready;

    // recognizer step for a received byte
    sua_rx_match u_match (
        .frame_state  (frame_reg),
        .rx_byte      (s_tdata),
        .address_byte (address_byte_reg),
        .ua_control   (ua_control_reg),
        .res          (match)
    );

    assign timer_inc = timer_reg + 16'd1;

    // next handshake state for the request at the input
    always_comb begin
        mode_next     = mode_reg;
        frame_next    = frame_reg;
        timer_next    = timer_reg;
        tries_next    = tries_reg;
        is_frame_next = 1'b0;
        case (s_tuser)
            sua_pkg::ACT_START: begin
                is_frame_next = 1'b1;
            end
            sua_pkg::ACT_BYTE: begin
                if (mode_reg == sua_pkg::MODE_WAIT) begin
                    frame_next = match.next_state;
                    if (match.complete) begin
                        mode_next  = sua_pkg::MODE_DONE;
                        timer_next = 16'd0;
                    end
                end
            end
            sua_pkg::ACT_TICK: begin
                if (mode_reg == sua_pkg::MODE_WAIT) begin
                    timer_next = timer_inc;
                    if (timer_inc >= timeout_ticks_reg) begin
                        if (tries_reg >= try_limit_reg) begin
                            mode_next  = sua_pkg::MODE_FAIL;
                            frame_next = sua_pkg::FS_START;
                            timer_next = 16'd0;
                        end else begin
                            is_frame_next = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        // sending set restarts the attempt
        if (is_frame_next) begin
            mode_next  = sua_pkg::MODE_WAIT;
            frame_next = sua_pkg::FS_START;
            timer_next = 16'd0;
            tries_next = (s_tuser == sua_pkg::ACT_START) ? 4'd1 : (tries_reg + 4'd1);
        end
    end

    // status after the request
    always_comb begin
        case (mode_next)
            sua_pkg::MODE_DONE: status_next = sua_pkg::STAT_DONE;
            sua_pkg::MODE_FAIL: status_next = sua_pkg::STAT_FAIL;
            default:            status_next = sua_pkg::STAT_WAIT;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sua_pkg::MODE_IDLE;
            frame_reg <= sua_pkg::FS_START;
            timer_reg <= 16'd0;
            tries_reg <= 4'd0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            frame_reg <= frame_next;
            timer_reg <= timer_next;
            tries_reg <= tries_next;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            beat_reg      <= 3'd0;
            is_frame_reg  <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
            beat_reg      <= 3'd0;
            is_frame_reg  <= is_frame_next;
        end else if (out_fire) begin
            if (last_beat) begin
                out_valid_reg <= 1'b0;
            end else begin
                beat_reg <= beat_reg + 3'd1;
            end
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            addr_reg   <= address_byte_reg;
            ctrl_reg   <= set_control_reg;
            status_reg <= status_next;
        end
    end

    // set frame byte for the current beat
    always_comb begin
        case (beat_reg)
            3'd1:    tx_byte = addr_reg;
            3'd2:    tx_byte = ctrl_reg;
            3'd3:    tx_byte = addr_reg ^ ctrl_reg;
            default: tx_byte = sua_pkg::FLAG_BYTE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_beat;
    assign m_tdata  = {5'd0, status_reg, is_frame_reg, (is_frame_reg ? tx_byte : 8'd0)};

`ifndef SYNTH
    // beat counter stays within the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (beat_reg <= sua_pkg::BEAT_LAST))
        else $error("beat counter past end of frame");

    // a single-beat result never advances the beat counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !is_frame_reg) |-> (beat_reg == 3'd0))
        else $error("beat counter moved on a single-beat result");

    // a start request yields a frame from its first byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (s_tuser == sua_pkg::ACT_START)) |=>
            (out_valid_reg && is_frame_reg && (beat_reg == 3'd0)))
        else $error("start request did not load a set frame");

    // recognizer rests at start outside the waiting mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != sua_pkg::MODE_WAIT) |-> (frame_reg == sua_pkg::FS_START))
        else $error("recognizer active outside waiting mode");

    // at least one set frame has gone out while waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == sua_pkg::MODE_WAIT) |-> (tries_reg != 4'd0))
        else $error("waiting without a set frame sent");
`endif

endmodule

// ===== verif/set_ua_link_handshake_unit_test.sv =====
// self-checking testbench for the set/ua link handshake block: stream stimulus, apb setup, scoreboard
`timescale 1ns / 1ps

module set_ua_link_handshake_unit_test;

    // the one action code the package leaves unnamed, which the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;

    // one beat on the result channel
    typedef struct {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       last;
        logic [1:0] status;
    } tx_beat_t;

    // keeps a private copy of the link state and registers, and the beats still owed
    class link_beat_tracker;
        logic [15:0]           timeout_ticks = sua_pkg::RST_TIMEOUT;
        logic [3:0]            try_limit     = sua_pkg::RST_MAXTRIES;
        logic [7:0]            address_byte  = sua_pkg::RST_ADDRESS;
        logic [7:0]            set_control   = sua_pkg::RST_SETCTRL;
        logic [7:0]            ua_control    = sua_pkg::RST_UACTRL;
        sua_pkg::link_mode_t   mode          = sua_pkg::MODE_IDLE;
        sua_pkg::frame_state_t rx_state      = sua_pkg::FS_START;
        logic [15:0]           tick_count    = '0;
        logic [3:0]            sets_sent     = '0;
        tx_beat_t              owed_beats[$];
        int                    failures      = 0;

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                sua_pkg::REG_TIMEOUT:  timeout_ticks = value[15:0];
                sua_pkg::REG_MAXTRIES: try_limit     = value[3:0];
                sua_pkg::REG_ADDRESS:  address_byte  = value[7:0];
                sua_pkg::REG_SETCTRL:  set_control   = value[7:0];
                sua_pkg::REG_UACTRL:   ua_control    = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [1:0] status_now();
            if (mode == sua_pkg::MODE_DONE) return sua_pkg::STAT_DONE;
            if (mode == sua_pkg::MODE_FAIL) return sua_pkg::STAT_FAIL;
            return sua_pkg::STAT_WAIT;
        endfunction

        function void owe_beat(logic [7:0] b, logic valid, logic lst);
            tx_beat_t beat;
            beat.tx_byte  = b;
            beat.tx_valid = valid;
            beat.last     = lst;
            beat.status   = status_now();
            owed_beats.push_back(beat);
        endfunction

        // (re)send the set frame and restart the wait
        function void queue_set_frame();
            mode       = sua_pkg::MODE_WAIT;
            rx_state   = sua_pkg::FS_START;
            tick_count = '0;
            sets_sent  = sets_sent + 4'd1;
            owe_beat(sua_pkg::FLAG_BYTE, 1'b1, 1'b0);
            owe_beat(address_byte, 1'b1, 1'b0);
            owe_beat(set_control, 1'b1, 1'b0);
            owe_beat(address_byte ^ set_control, 1'b1, 1'b0);
            owe_beat(sua_pkg::FLAG_BYTE, 1'b1, 1'b1);
        endfunction

        // ua recognizer: the match test always wins over the flag test
        function void advance_recognizer(logic [7:0] c);
            case (rx_state)
                sua_pkg::FS_START: begin
                    if (c == sua_pkg::FLAG_BYTE) rx_state = sua_pkg::FS_FLAG;
                end
                sua_pkg::FS_FLAG: begin
                    if (c == address_byte) rx_state = sua_pkg::FS_ADDR;
                    else if (c != sua_pkg::FLAG_BYTE) rx_state = sua_pkg::FS_START;
                end
                sua_pkg::FS_ADDR: begin
                    if (c == ua_control) rx_state = sua_pkg::FS_CTRL;
                    else if (c == sua_pkg::FLAG_BYTE) rx_state = sua_pkg::FS_FLAG;
                    else rx_state = sua_pkg::FS_START;
                end
                sua_pkg::FS_CTRL: begin
                    if (c == (address_byte ^ ua_control)) rx_state = sua_pkg::FS_CHECK;
                    else if (c == sua_pkg::FLAG_BYTE) rx_state = sua_pkg::FS_FLAG;
                    else rx_state = sua_pkg::FS_START;
                end
                default: begin
                    if (c == sua_pkg::FLAG_BYTE) begin
                        mode       = sua_pkg::MODE_DONE;
                        tick_count = '0;
                    end
                    rx_state = sua_pkg::FS_START;
                end
            endcase
        endfunction

        // work out the beats caused by one accepted request
        function void note_request(logic [1:0] action, logic [7:0] rx);
            if (action == sua_pkg::ACT_START) begin
                sets_sent = '0;
                queue_set_frame();
                return;
            end
            if (action == sua_pkg::ACT_BYTE && mode == sua_pkg::MODE_WAIT) begin
                advance_recognizer(rx);
            end else if (action == sua_pkg::ACT_TICK && mode == sua_pkg::MODE_WAIT) begin
                tick_count = tick_count + 16'd1;
                if (tick_count >= timeout_ticks) begin
                    if (sets_sent >= try_limit) begin
                        mode       = sua_pkg::MODE_FAIL;
                        rx_state   = sua_pkg::FS_START;
                        tick_count = '0;
                    end else begin
                        queue_set_frame();
                        return;
                    end
                end
            end
            owe_beat(8'h00, 1'b0, 1'b1);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                         exp_val, act_val);
                failures++;
            end
        endfunction

        function void check_beat(logic [15:0] data, logic tlast);
            tx_beat_t beat;
            if (owed_beats.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %0h tlast %0b",
                         $time, data, tlast);
                failures++;
                return;
            end
            beat = owed_beats.pop_front();
            compare_field("tx_byte", beat.tx_byte, data[7:0]);
            compare_field("tx_valid", beat.tx_valid, data[8]);
            compare_field("link_status", beat.status, data[10:9]);
            compare_field("tlast", beat.last, tlast);
        endfunction

        function int pending();
            return owed_beats.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] tx_byte, [8] tx_valid, [10:9] link_status, zero fill
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    link_beat_tracker sb;
    int  requests_sent = 0;
    int  burst_left    = 1;
    bit  steady        = 0;
    bit  hold_request  = 0;
    int  quiet_cycles  = 0;

    set_ua_link_handshake_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always #2 aclk = ~aclk;

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: stall pattern redrawn at each wrap of its position, plus one long hold-off on demand
    initial begin
        logic [15:0] stall_pattern;
        int          pat_pos;
        m_tready = 1'b0;
        stall_pattern = 16'hffff;
        pat_pos = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                if (pat_pos == 0) begin
                    case ($urandom_range(0, 3))
                        0: stall_pattern = 16'hffff;
                        1: stall_pattern = 16'($urandom()) | 16'h0001;
                        2: stall_pattern = 16'($urandom() & $urandom()) | 16'h0001;
                        default: stall_pattern = ~(16'($urandom() & $urandom()) & 16'hfffe);
                    endcase
                end
                m_tready <= stall_pattern[pat_pos % 16];
                pat_pos = (pat_pos + 1) % 48;
            end
        end
    end

    // offer one request and wait for it to be taken; bursts with random gaps unless steady
    task automatic send_request(input logic [1:0] act, input logic [7:0] rx);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(act, rx);
        requests_sent++;
        if (!steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 10);
                gap = $urandom_range(1, 8);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // stop offering and let every owed result come out
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle; pready is tied high
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_register(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input logic [15:0] tmo, input logic [3:0] tries,
                                input logic [7:0] addr, input logic [7:0] setc,
                                input logic [7:0] uac);
        drain();
        apb_write(sua_pkg::REG_TIMEOUT, {16'h0, tmo});
        apb_write(sua_pkg::REG_MAXTRIES, {28'h0, tries});
        apb_write(sua_pkg::REG_ADDRESS, {24'h0, addr});
        apb_write(sua_pkg::REG_SETCTRL, {24'h0, setc});
        apb_write(sua_pkg::REG_UACTRL, {24'h0, uac});
    endtask

    // random traffic: mostly ua frames (some corrupted) and ticks, with noise mixed in
    task automatic run_phase(input int n_items, input bit pressure);
        int         first;
        int         pick;
        int         pos;
        bit         held;
        bit         paused;
        logic [7:0] fr[5];
        first  = requests_sent;
        held   = 0;
        paused = 0;
        steady = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(1, 10);
        send_request(sua_pkg::ACT_START, 8'($urandom_range(0, 255)));
        while (requests_sent - first < n_items) begin
            if (pressure && !held && requests_sent - first >= 10) begin
                hold_request = 1'b1;
                held = 1;
            end
            if (pressure && !paused && requests_sent - first >= 25) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
                paused = 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_request(sua_pkg::ACT_START, 8'($urandom_range(0, 255)));
            end else if (pick < 50) begin
                fr[0] = sua_pkg::FLAG_BYTE;
                fr[1] = sb.address_byte;
                fr[2] = sb.ua_control;
                fr[3] = sb.address_byte ^ sb.ua_control;
                fr[4] = sua_pkg::FLAG_BYTE;
                // broken frame: one byte replaced, sometimes by a flag
                if ($urandom_range(0, 9) < 3) begin
                    pos = $urandom_range(0, 4);
                    fr[pos] = ($urandom_range(0, 3) == 0) ? sua_pkg::FLAG_BYTE : 8'($urandom());
                end
                if ($urandom_range(0, 3) == 0) send_request(sua_pkg::ACT_BYTE, sua_pkg::FLAG_BYTE);
                foreach (fr[i]) send_request(sua_pkg::ACT_BYTE, fr[i]);
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 3))
                    send_request(sua_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                send_request(sua_pkg::ACT_BYTE, ($urandom_range(0, 4) == 0) ?
                             sua_pkg::FLAG_BYTE : 8'($urandom()));
            end else begin
                send_request(ACT_UNUSED, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // directed sequence under the reset register values (address 03, ua 07, check 04)
    logic [9:0] directed_script[] = '{
        {sua_pkg::ACT_TICK, 8'hff},                             // tick while idle is ignored
        {ACT_UNUSED, 8'h00},                                    // unused action is ignored
        {sua_pkg::ACT_START, 8'ha5},
        {sua_pkg::ACT_BYTE, 8'h7e}, {sua_pkg::ACT_BYTE, 8'h7e}, // repeated flag stays in sync
        {sua_pkg::ACT_BYTE, 8'h55},                             // wrong address restarts
        {sua_pkg::ACT_BYTE, 8'h7e}, {sua_pkg::ACT_BYTE, 8'h03},
        {sua_pkg::ACT_BYTE, 8'h7e},                             // flag after address
        {sua_pkg::ACT_BYTE, 8'h03}, {sua_pkg::ACT_BYTE, 8'h07},
        {sua_pkg::ACT_BYTE, 8'h7e},                             // flag after control
        {sua_pkg::ACT_BYTE, 8'h03}, {sua_pkg::ACT_BYTE, 8'h07},
        {sua_pkg::ACT_BYTE, 8'h04},
        {sua_pkg::ACT_BYTE, 8'h00},                             // missing closing flag
        {sua_pkg::ACT_BYTE, 8'h7e}, {sua_pkg::ACT_BYTE, 8'h03},
        {sua_pkg::ACT_BYTE, 8'h07}, {sua_pkg::ACT_BYTE, 8'h04},
        {sua_pkg::ACT_BYTE, 8'h7e},                             // complete ua, link up
        {sua_pkg::ACT_BYTE, 8'hff},                             // byte after completion
        {sua_pkg::ACT_START, 8'h00},                            // restart while done
        {sua_pkg::ACT_TICK, 8'h01}, {sua_pkg::ACT_TICK, 8'h02}, // first retry
        {sua_pkg::ACT_TICK, 8'h04}, {sua_pkg::ACT_TICK, 8'h08}, // second retry
        {sua_pkg::ACT_TICK, 8'h10}, {sua_pkg::ACT_TICK, 8'h20}  // give up
    };

    // main sequence
    initial begin
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = sua_pkg::ACT_START;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        sb = new;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_script[i])
            send_request(directed_script[i][9:8], directed_script[i][7:0]);

        // extremes: zero timeout and zero tries give up on the first tick
        apply_config(16'd0, 4'd0, 8'h00, 8'hff, 8'h00);
        run_phase(30, 0);
        apply_config(16'd1, 4'd15, 8'hff, 8'h00, 8'hff);
        run_phase(40, 0);
        // flag value used as address and ua control
        apply_config(16'hffff, 4'd1, sua_pkg::FLAG_BYTE, 8'h5a, sua_pkg::FLAG_BYTE);
        run_phase(30, 0);
        for (int p = 0; p < 3; p++) begin
            apply_config(16'($urandom_range(1, 6)), 4'($urandom_range(1, 4)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            run_phase(45, p == 0);
        end
        drain();

        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sua_pkg.sv
hw/rtl/sua_rx_match.sv
hw/rtl/set_ua_link_handshake_unit.sv
verif/set_ua_link_handshake_unit_test.sv
